/* rtl/wep_pkg.sv */
// ----------------------------------------------------------------------------
// wep_pkg: shared types for the watch entry pool
// Request and status codes, datapath operation codes and the status bundle
// that the datapath returns to the controller.
// ----------------------------------------------------------------------------
package wep_pkg;

  // Maximum number of results one list request emits
  localparam int LIST_MAX = 32;
  localparam int CNT_W    = $clog2(LIST_MAX);
  localparam int NUM_W    = 5;
  localparam int VAL_W    = 32;

  typedef enum logic [1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_CHECK  = 2'd2,
    REQ_LIST   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } res_status_t;

  // One operation per cycle, issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_ALLOC_FULL,
    OP_ALLOC_START,
    OP_ALLOC_POP,
    OP_ALLOC_LINK,
    OP_NOT_FOUND,
    OP_DEL_START,
    OP_DEL_FETCH,
    OP_DEL_WALK,
    OP_DEL_FREE,
    OP_CHK_START,
    OP_CHK_UPDATE,
    OP_LIST_EMPTY,
    OP_LIST_START,
    OP_LIST_EMIT
  } dp_op_t;

  // Datapath status seen by the controller
  typedef struct packed {
    req_t req;
    logic free_none;
    logic hit;
    logic head_none;
    logic head_is_num;
    logic link_is_num;
    logic list_last;
  } sts_t;

endpackage

/* rtl/wep_ctrl.sv */
// ----------------------------------------------------------------------------
// wep_ctrl: request sequencer for the watch entry pool
// Steps each request through its operations and drives busy.
// ----------------------------------------------------------------------------
module wep_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  wep_pkg::sts_t  sts,
  output wep_pkg::dp_op_t op,
  output logic           busy
);
  import wep_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ALLOC_POP,
    S_ALLOC_LINK,
    S_DEL_FETCH,
    S_DEL_WALK,
    S_DEL_FREE,
    S_CHK_UPDATE,
    S_LIST_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  // Pick the operation and the next state
  always_comb begin
    op         = OP_NONE;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          op         = OP_LATCH;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.req)
          REQ_ALLOC: begin
            if (sts.free_none) begin
              op         = OP_ALLOC_FULL;
              state_next = S_IDLE;
            end else begin
              op         = OP_ALLOC_START;
              state_next = S_ALLOC_POP;
            end
          end
          REQ_DELETE: begin
            if (!sts.hit) begin
              op         = OP_NOT_FOUND;
              state_next = S_IDLE;
            end else begin
              op         = OP_DEL_START;
              state_next = S_DEL_FETCH;
            end
          end
          REQ_CHECK: begin
            if (!sts.hit) begin
              op         = OP_NOT_FOUND;
              state_next = S_IDLE;
            end else begin
              op         = OP_CHK_START;
              state_next = S_CHK_UPDATE;
            end
          end
          default: begin
            if (sts.head_none) begin
              op         = OP_LIST_EMPTY;
              state_next = S_IDLE;
            end else begin
              op         = OP_LIST_START;
              state_next = S_LIST_EMIT;
            end
          end
        endcase
      end
      S_ALLOC_POP: begin
        op         = OP_ALLOC_POP;
        state_next = S_ALLOC_LINK;
      end
      S_ALLOC_LINK: begin
        op         = OP_ALLOC_LINK;
        state_next = S_IDLE;
      end
      S_DEL_FETCH: begin
        op         = OP_DEL_FETCH;
        state_next = sts.head_is_num ? S_DEL_FREE : S_DEL_WALK;
      end
      S_DEL_WALK: begin
        op         = OP_DEL_WALK;
        state_next = sts.link_is_num ? S_DEL_FREE : S_DEL_WALK;
      end
      S_DEL_FREE: begin
        op         = OP_DEL_FREE;
        state_next = S_IDLE;
      end
      S_CHK_UPDATE: begin
        op         = OP_CHK_UPDATE;
        state_next = S_IDLE;
      end
      S_LIST_EMIT: begin
        op         = OP_LIST_EMIT;
        state_next = sts.list_last ? S_IDLE : S_LIST_EMIT;
      end
      default: begin
        op         = OP_NONE;
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state and busy
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

/* rtl/wep_dp.sv */
// ----------------------------------------------------------------------------
// wep_dp: storage and datapath of the watch entry pool
// Link and value memories, list pointers, active flags and result registers.
// ----------------------------------------------------------------------------
module wep_dp #(
  parameter int NUM_ENTRIES = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  wep_pkg::dp_op_t        op,
  input  logic [1:0]             req_type,
  input  logic [4:0]             entry_number,
  input  logic [31:0]            entry_value,
  output wep_pkg::sts_t          sts,
  output logic                   result_valid,
  output logic [1:0]             status,
  output logic [4:0]             result_number,
  output logic [31:0]            old_value,
  output logic                   changed,
  output logic                   last
);
  import wep_pkg::*;

  localparam int LW = $clog2(NUM_ENTRIES + 1);
  localparam int EW = $clog2(NUM_ENTRIES);
  localparam int CW = (LW > NUM_W) ? LW : NUM_W;
  localparam logic [LW-1:0] NONE = LW'(NUM_ENTRIES);

  // Memories
  logic [LW-1:0]    link_mem [NUM_ENTRIES];
  logic [VAL_W-1:0] val_mem  [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] link_ok;
  logic [NUM_ENTRIES-1:0] mark;

  // Pointers
  logic [LW-1:0] head;
  logic [LW-1:0] tail;
  logic [LW-1:0] free_head;

  // Request and walk registers
  req_t             req_q;
  logic [NUM_W-1:0] num_q;
  logic [VAL_W-1:0] val_q;
  logic [LW-1:0]    cur;
  logic [LW-1:0]    nxt;
  logic [VAL_W-1:0] held;
  logic [CNT_W-1:0] cnt;

  // Read port
  logic [EW-1:0]    rd_addr;
  logic [EW-1:0]    rd_addr_q;
  logic [LW-1:0]    link_q;
  logic             link_ok_q;
  logic [LW-1:0]    link_rd;
  logic [VAL_W-1:0] val_rd;

  // Write ports
  logic             lw_en;
  logic [EW-1:0]    lw_addr;
  logic [LW-1:0]    lw_data;
  logic             vw_en;
  logic [EW-1:0]    vw_addr;

  logic [CW-1:0]    num_c;
  logic [EW-1:0]    num_idx;
  logic [LW-1:0]    num_l;
  logic             num_in_range;

  // Result fields
  logic             emit;
  res_status_t      o_status;
  logic [NUM_W-1:0] o_num;
  logic [VAL_W-1:0] o_val;
  logic             o_chg;
  logic             o_last;

  assign num_c        = CW'(num_q);
  assign num_idx      = EW'(num_c);
  assign num_l        = LW'(num_c);
  assign num_in_range = (num_c < CW'(NUM_ENTRIES));

  // Unwritten links read as their reset chain
  assign link_rd = link_ok_q ? link_q : (LW'(rd_addr_q) + LW'(1));

  // Status to the controller
  always_comb begin
    sts.req         = req_q;
    sts.free_none   = (free_head == NONE);
    sts.hit         = num_in_range && mark[num_idx];
    sts.head_none   = (head == NONE);
    sts.head_is_num = (head == num_l);
    sts.link_is_num = (link_rd == num_l);
    sts.list_last   = (link_rd == NONE) || (cnt == CNT_W'(LIST_MAX - 1));
  end

  // Select the read address
  always_comb begin
    case (op)
      OP_ALLOC_START:               rd_addr = free_head[EW-1:0];
      OP_DEL_START, OP_CHK_START:   rd_addr = num_idx;
      OP_LIST_START, OP_DEL_FETCH:  rd_addr = head[EW-1:0];
      OP_DEL_WALK, OP_LIST_EMIT:    rd_addr = link_rd[EW-1:0];
      default:                      rd_addr = num_idx;
    endcase
  end

  // Drive the memory writes
  always_comb begin
    lw_en   = 1'b0;
    lw_addr = cur[EW-1:0];
    lw_data = NONE;
    vw_en   = 1'b0;
    vw_addr = num_idx;
    case (op)
      OP_ALLOC_POP: begin
        lw_en   = 1'b1;
        vw_en   = 1'b1;
        vw_addr = cur[EW-1:0];
      end
      OP_ALLOC_LINK: begin
        lw_en   = (tail != NONE);
        lw_addr = tail[EW-1:0];
        lw_data = cur;
      end
      OP_DEL_WALK: begin
        lw_en   = sts.link_is_num;
        lw_data = nxt;
      end
      OP_DEL_FREE: begin
        lw_en   = 1'b1;
        lw_addr = num_idx;
        lw_data = free_head;
      end
      OP_CHK_UPDATE: begin
        vw_en = 1'b1;
      end
      default: begin
        lw_en = 1'b0;
      end
    endcase
  end

  // Link memory, registered read
  always_ff @(posedge clk) begin
    if (lw_en) begin
      link_mem[lw_addr] <= lw_data;
    end
    link_q    <= link_mem[rd_addr];
    link_ok_q <= link_ok[rd_addr];
    rd_addr_q <= rd_addr;
  end

  // Value memory, registered read
  always_ff @(posedge clk) begin
    if (vw_en) begin
      val_mem[vw_addr] <= val_q;
    end
    val_rd <= val_mem[rd_addr];
  end

  // Pointers, active flags and link valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= NONE;
      tail      <= NONE;
      free_head <= '0;
      link_ok   <= '0;
      mark      <= '0;
    end else begin
      if (lw_en) begin
        link_ok[lw_addr] <= 1'b1;
      end
      case (op)
        OP_ALLOC_POP: begin
          free_head         <= link_rd;
          mark[cur[EW-1:0]] <= 1'b1;
        end
        OP_ALLOC_LINK: begin
          if (tail == NONE) begin
            head <= cur;
          end
          tail <= cur;
        end
        OP_DEL_FETCH: begin
          if (head == num_l) begin
            head <= link_rd;
            if (tail == num_l) begin
              tail <= NONE;
            end
          end
        end
        OP_DEL_WALK: begin
          if (sts.link_is_num && (tail == num_l)) begin
            tail <= cur;
          end
        end
        OP_DEL_FREE: begin
          mark[num_idx] <= 1'b0;
          free_head     <= num_l;
        end
        default: begin
          head <= head;
        end
      endcase
    end
  end

  // Request latch and walk registers
  always_ff @(posedge clk) begin
    case (op)
      OP_LATCH: begin
        req_q <= req_t'(req_type);
        num_q <= entry_number;
        val_q <= entry_value;
      end
      OP_ALLOC_START: cur <= free_head;
      OP_DEL_FETCH: begin
        nxt  <= link_rd;
        held <= val_rd;
        cur  <= head;
      end
      OP_DEL_WALK: begin
        if (!sts.link_is_num) begin
          cur <= link_rd;
        end
      end
      OP_LIST_START: begin
        cur <= head;
        cnt <= '0;
      end
      OP_LIST_EMIT: begin
        cur <= link_rd;
        cnt <= cnt + CNT_W'(1);
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

  // Form the result
  always_comb begin
    emit     = 1'b1;
    o_status = ST_OK;
    o_num    = '0;
    o_val    = '0;
    o_chg    = 1'b0;
    o_last   = 1'b1;
    case (op)
      OP_ALLOC_FULL: o_status = ST_FULL;
      OP_NOT_FOUND: begin
        o_status = ST_NOT_FOUND;
        o_num    = num_q;
      end
      OP_LIST_EMPTY: o_status = ST_EMPTY;
      OP_ALLOC_LINK: o_num = NUM_W'(cur);
      OP_DEL_FREE: begin
        o_num = num_q;
        o_val = held;
      end
      OP_CHK_UPDATE: begin
        o_num = num_q;
        o_val = val_rd;
        o_chg = (val_rd != val_q);
      end
      OP_LIST_EMIT: begin
        o_num  = NUM_W'(cur);
        o_val  = val_rd;
        o_last = sts.list_last;
      end
      default: emit = 1'b0;
    endcase
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      status        <= o_status;
      result_number <= o_num;
      old_value     <= o_val;
      changed       <= o_chg;
      last          <= o_last;
    end
  end

endmodule

/* rtl/watch_entry_pool.sv */
// Each request is latched, then decoded; a failed request ends at decode,
// allocate then pops and links, check updates, delete fetches, walks the
// active list up to the entry and frees it, and list emits one result a cycle.
// The delete walk and list follow one link per cycle through the link memory.
// A new request is taken in the cycle the final result shows; results cannot
// be stalled. Synchronous reset: all entries free, active list empty.
// ----------------------------------------------------------------------------
// watch_entry_pool: fixed pool of watch entries
// Free stack plus ordered active list with allocate, delete, check and list.
// ----------------------------------------------------------------------------
module watch_entry_pool #(
  parameter int NUM_ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [4:0]  entry_number,
  input  logic [31:0] entry_value,
  output logic        result_valid,
  output logic [1:0]  status,
  output logic [4:0]  result_number,
  output logic [31:0] old_value,
  output logic        changed,
  output logic        last
);
  import wep_pkg::*;

  dp_op_t op;
  sts_t   sts;

  // Sequence each request
  wep_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .op    (op),
    .busy  (busy)
  );

  // Storage and results
  wep_dp #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .op            (op),
    .req_type      (req_type),
    .entry_number  (entry_number),
    .entry_value   (entry_value),
    .sts           (sts),
    .result_valid  (result_valid),
    .status        (status),
    .result_number (result_number),
    .old_value     (old_value),
    .changed       (changed),
    .last          (last)
  );

endmodule

/* rtl/wep_checker.sv */
// ----------------------------------------------------------------------------
// wep_checker: port-level checks for the watch entry pool
// Watches request acceptance and the shape of the result stream.
// ----------------------------------------------------------------------------
module wep_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        result_valid,
  input logic [1:0]  status,
  input logic        changed,
  input logic        last
);
  import wep_pkg::*;

  // Go busy after taking a request
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after request");

  // Final result frees the block in the same cycle
  a_idle_on_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |-> !busy)
    else $error("busy held with final result");

  // A list stream has no gaps
  a_stream_gapless: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |=> result_valid)
    else $error("gap in list result stream");

  // Failed requests give one final result
  a_fail_single: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status != ST_OK) |-> last && !changed)
    else $error("failed request result malformed");

endmodule

bind watch_entry_pool wep_checker u_wep_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .status       (status),
  .changed      (changed),
  .last         (last)
);

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the watch entry pool
// Drives allocate, delete, check and list requests through the start/busy
// handshake. Each accepted request is predicted with a private model of the
// free stack and the active list. Every result strobe is compared with the
// oldest expected result.
// ----------------------------------------------------------------------------
module tb_top;
  import wep_pkg::*;

  localparam int POOL_SIZE   = 32;
  localparam int NO_ENTRY    = POOL_SIZE;
  localparam int CYCLE_LIMIT = 300000;
  localparam int REPORT_MAX  = 10;

  typedef struct {
    res_status_t status;
    logic [4:0]  number;
    logic [31:0] value;
    logic        changed;
    logic        last;
  } watch_result_t;

  logic        clk;
  logic        rst          = 1'b1;
  logic        start        = 1'b0;
  logic [1:0]  req_type     = REQ_ALLOC;
  logic [4:0]  entry_number = '0;
  logic [31:0] entry_value  = '0;
  logic        busy;
  logic        result_valid;
  logic [1:0]  status;
  logic [4:0]  result_number;
  logic [31:0] old_value;
  logic        changed;
  logic        last;

  // Shadow copy of the pool
  logic [5:0]    pool_link   [POOL_SIZE];
  logic [31:0]   pool_value  [POOL_SIZE];
  logic          pool_active [POOL_SIZE];
  logic [5:0]    active_top;
  logic [5:0]    free_top;
  watch_result_t pending_results[$];

  int  mismatch_count = 0;
  int  cycle_count    = 0;
  bit  idle_enabled   = 1'b1;

  watch_entry_pool #(
    .NUM_ENTRIES(POOL_SIZE)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .entry_number (entry_number),
    .entry_value  (entry_value),
    .result_valid (result_valid),
    .status       (status),
    .result_number(result_number),
    .old_value    (old_value),
    .changed      (changed),
    .last         (last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Reset state of the shadow pool
  initial begin
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_link[i]   = 6'(i + 1);
      pool_value[i]  = '0;
      pool_active[i] = 1'b0;
    end
    active_top = 6'(NO_ENTRY);
    free_top   = '0;
  end

  function automatic void expect_result(res_status_t st, logic [4:0] num,
                                        logic [31:0] val, logic chg, logic lst);
    watch_result_t r;
    r.status  = st;
    r.number  = num;
    r.value   = val;
    r.changed = chg;
    r.last    = lst;
    pending_results.push_back(r);
  endfunction

  // Update the shadow pool for one accepted request and queue its results
  function automatic void predict_request(req_t kind, logic [4:0] num,
                                          logic [31:0] val);
    logic [5:0]  cur;
    logic [5:0]  nxt;
    logic [5:0]  slot;
    logic [31:0] held;
    int          emitted;
    case (kind)
      REQ_ALLOC: begin
        if (free_top >= NO_ENTRY) begin
          expect_result(ST_FULL, '0, '0, 1'b0, 1'b1);
        end else begin
          slot = free_top;
          free_top = pool_link[slot];
          pool_link[slot]   = 6'(NO_ENTRY);
          pool_value[slot]  = val;
          pool_active[slot] = 1'b1;
          if (active_top >= NO_ENTRY) begin
            active_top = slot;
          end else begin
            // walk to the tail and append
            cur = active_top;
            while (pool_link[cur] < NO_ENTRY) cur = pool_link[cur];
            pool_link[cur] = slot;
          end
          expect_result(ST_OK, slot[4:0], '0, 1'b0, 1'b1);
        end
      end
      REQ_DELETE: begin
        if (!pool_active[num]) begin
          expect_result(ST_NOT_FOUND, num, '0, 1'b0, 1'b1);
        end else begin
          if (active_top == 6'(num)) begin
            active_top = pool_link[num];
          end else begin
            // unlink from its predecessor
            cur = active_top;
            while (cur < NO_ENTRY && pool_link[cur] != 6'(num)) cur = pool_link[cur];
            if (cur < NO_ENTRY) pool_link[cur] = pool_link[num];
          end
          held = pool_value[num];
          pool_active[num] = 1'b0;
          pool_link[num]   = free_top;
          free_top         = 6'(num);
          expect_result(ST_OK, num, held, 1'b0, 1'b1);
        end
      end
      REQ_CHECK: begin
        if (!pool_active[num]) begin
          expect_result(ST_NOT_FOUND, num, '0, 1'b0, 1'b1);
        end else begin
          held = pool_value[num];
          pool_value[num] = val;
          expect_result(ST_OK, num, held, held != val, 1'b1);
        end
      end
      default: begin
        if (active_top >= NO_ENTRY) begin
          expect_result(ST_EMPTY, '0, '0, 1'b0, 1'b1);
        end else begin
          cur = active_top;
          emitted = 0;
          while (cur < NO_ENTRY && emitted < LIST_MAX) begin
            nxt = pool_link[cur];
            expect_result(ST_OK, cur[4:0], pool_value[cur], 1'b0,
                          nxt >= NO_ENTRY || emitted + 1 == LIST_MAX);
            emitted++;
            cur = nxt;
          end
        end
      end
    endcase
  endfunction

  // Pick an active entry at random, or -1 when the list is empty
  function automatic int pick_active();
    int ids[$];
    for (int i = 0; i < POOL_SIZE; i++) if (pool_active[i]) ids.push_back(i);
    if (ids.size() == 0) return -1;
    return ids[$urandom_range(0, ids.size() - 1)];
  endfunction

  // Send one request, with an optional idle burst ahead of it
  task automatic send_request(input req_t kind, input logic [4:0] num,
                              input logic [31:0] val);
    int gap;
    gap = 0;
    if (idle_enabled && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 17);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    req_type     <= kind;
    entry_number <= num;
    entry_value  <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_request(kind, num, val);
  endtask

  // Lookups and list on an empty pool
  task automatic test_empty_pool();
    send_request(REQ_LIST, 5'd0, 32'h0);
    send_request(REQ_DELETE, 5'd0, 32'h0);
    send_request(REQ_CHECK, 5'd31, 32'hFFFF_FFFF);
    send_request(REQ_DELETE, 5'd31, 32'h0);
  endtask

  // Fill every entry, overflow once, then list the full pool
  task automatic test_fill_pool();
    logic [31:0] val;
    for (int i = 0; i < POOL_SIZE; i++) begin
      val = (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom;
      send_request(REQ_ALLOC, 5'd0, val);
    end
    send_request(REQ_ALLOC, 5'd0, $urandom);
    send_request(REQ_LIST, 5'd0, 32'h0);
  endtask

  // Unlink head, tail and middle; check with and without a change
  task automatic test_unlink_and_check();
    send_request(REQ_DELETE, 5'd0, 32'h0);
    send_request(REQ_DELETE, 5'd31, 32'h0);
    send_request(REQ_DELETE, 5'd15, 32'h0);
    send_request(REQ_DELETE, 5'd15, 32'h0);
    send_request(REQ_CHECK, 5'd1, pool_value[1]);
    send_request(REQ_CHECK, 5'd2, ~pool_value[2]);
    send_request(REQ_CHECK, 5'd3, 32'hFFFF_FFFF);
    send_request(REQ_CHECK, 5'd31, 32'h1234_5678);
    send_request(REQ_ALLOC, 5'd0, 32'hA5A5_5A5A);
    send_request(REQ_ALLOC, 5'd0, 32'h0);
    send_request(REQ_LIST, 5'd0, 32'h0);
  endtask

  // Random mix in segments that lean toward filling or draining the pool
  task automatic test_random_traffic(input int count);
    int          alloc_weight;
    int          roll;
    int          pick;
    req_t        kind;
    logic [4:0]  num;
    logic [31:0] val;
    alloc_weight = 50;
    for (int i = 0; i < count; i++) begin
      if (i % 30 == 0) begin
        alloc_weight = ((i / 30) % 2 == 0) ? 15 : 70;
        idle_enabled = (i < count - 50) && ($urandom_range(0, 2) != 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < alloc_weight) begin
        kind = REQ_ALLOC;
      end else begin
        roll = $urandom_range(0, 9);
        kind = (roll < 4) ? REQ_DELETE : (roll < 8) ? REQ_CHECK : REQ_LIST;
      end
      val  = $urandom;
      if ($urandom_range(0, 15) == 0) val = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      pick = pick_active();
      num  = 5'($urandom_range(0, 31));
      if (pick >= 0 && $urandom_range(0, 4) != 0) begin
        num = 5'(pick);
        if (kind == REQ_CHECK && $urandom_range(0, 2) == 0) val = pool_value[pick];
      end
      send_request(kind, num, val);
    end
  endtask

  // Compare each result strobe with the oldest expected result
  always @(posedge clk) begin
    watch_result_t want;
    if (!rst && result_valid) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("Unexpected result: status %0d number %0d value %h changed %0d last %0d",
                   status, result_number, old_value, changed, last);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status || result_number !== want.number ||
            old_value !== want.value || changed !== want.changed ||
            last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display({"Mismatch: expected st %0d num %0d val %h chg %0d last %0d,",
                      " got st %0d num %0d val %h chg %0d last %0d"},
                     want.status, want.number, want.value, want.changed, want.last,
                     status, result_number, old_value, changed, last);
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_pool();
    test_fill_pool();
    test_unlink_and_check();
    test_random_traffic(160);
    // drop start and drain the remaining results
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/wep_pkg.sv
rtl/wep_ctrl.sv
rtl/wep_dp.sv
rtl/watch_entry_pool.sv
rtl/wep_checker.sv
tb/tb_top.sv
